// ===== rtl/core/assert_macros.svh =====
// assertion helpers for the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/rv32_pkg.sv =====
package rv32_pkg;

  localparam int MEM_BYTES_DEF = 65536;

  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [2:0] ST_EXEC   = 3'd0;
  localparam logic [2:0] ST_LOADED = 3'd1;
  localparam logic [2:0] ST_LOADOR = 3'd2;
  localparam logic [2:0] ST_HALT   = 3'd3;
  localparam logic [2:0] ST_EXIT   = 3'd4;
  localparam logic [2:0] ST_UNK    = 3'd5;
  localparam logic [2:0] ST_READ   = 3'd6;
  localparam logic [2:0] ST_WRITE  = 3'd7;

  localparam logic [31:0] SYS_READ  = 32'd63;
  localparam logic [31:0] SYS_WRITE = 32'd64;
  localparam logic [31:0] SYS_EXIT  = 32'd94;

  localparam logic [0:0] CFG_START_PC  = 1'b0;
  localparam logic [0:0] CFG_STACK_TOP = 1'b1;

  typedef enum logic [1:0] {DOP_MUL, DOP_DIV} dop_t;

  typedef struct packed {
    logic        start;
    dop_t        op;
    logic [2:0]  f3;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_LDW, S_FETCH, S_DECODE, S_RDA, S_RDB, S_EXEC, S_MD,
    S_MEMRD, S_MEMWR, S_DONE
  } state_t;

endpackage

// ===== rtl/core/rv32_muldiv.sv =====
`include "assert_macros.svh"
module rv32_muldiv import rv32_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  md_req_t     req,
  output logic        busy,
  output logic        done,
  output logic [31:0] result
);
  // one shared adder: shift-add multiply or restoring divide, a bit a cycle
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] dv_r, dv_nxt;
  dop_t        op_r, op_nxt;
  logic [2:0]  f3_r, f3_nxt;
  logic        neg_r, neg_nxt, zero_r, zero_nxt, ovf_r, ovf_nxt;
  logic [31:0] a_r, a_nxt, res_r, res_nxt;
  logic        na, nb;
  logic [32:0] sum;
  logic [63:0] hi_fix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt; acc_r <= acc_nxt; dv_r <= dv_nxt; op_r <= op_nxt;
    f3_r <= f3_nxt; neg_r <= neg_nxt; zero_r <= zero_nxt; ovf_r <= ovf_nxt;
    a_r <= a_nxt; res_r <= res_nxt;
  end

  always_comb begin
    busy_nxt = busy_r; done_nxt = 1'b0; cnt_nxt = cnt_r; acc_nxt = acc_r;
    dv_nxt = dv_r; op_nxt = op_r; f3_nxt = f3_r; neg_nxt = neg_r;
    zero_nxt = zero_r; ovf_nxt = ovf_r; a_nxt = a_r; res_nxt = res_r;
    na = 1'b0; nb = 1'b0; sum = '0; hi_fix = '0;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      op_nxt = req.op;
      f3_nxt = req.f3;
      a_nxt = req.a;
      zero_nxt = (req.b == '0);
      ovf_nxt = 1'b0;
      if (req.op == DOP_MUL) begin
        // unsigned product, sign corrections applied at the end
        acc_nxt = {32'd0, req.a};
        dv_nxt = req.b;
        neg_nxt = 1'b0;
      end else begin
        na = !req.f3[0] && req.a[31];
        nb = !req.f3[0] && req.b[31];
        acc_nxt = {32'd0, na ? 32'd0 - req.a : req.a};
        dv_nxt = nb ? 32'd0 - req.b : req.b;
        neg_nxt = req.f3[1] ? na : (na != nb);
      end
    end else if (busy_r) begin
      if (op_r == DOP_MUL) begin
        sum = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, dv_r} : 33'd0);
        acc_nxt = {sum, acc_r[31:1]};
      end else begin
        sum = {1'b0, acc_r[62:31]} - {1'b0, dv_r};
        if (!sum[32]) acc_nxt = {sum[31:0], acc_r[30:0], 1'b1};
        else          acc_nxt = {acc_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == DOP_MUL) begin
          hi_fix = acc_nxt;
          // signed high corrections: subtract b when a<0 (mulh, mulhsu), a when b<0 (mulh)
          if ((f3_r == 3'd1 || f3_r == 3'd2) && a_r[31])
            hi_fix[63:32] = hi_fix[63:32] - dv_r;
          if (f3_r == 3'd1 && dv_r[31])
            hi_fix[63:32] = hi_fix[63:32] - a_r;
          res_nxt = (f3_r == 3'd0) ? hi_fix[31:0] : hi_fix[63:32];
        end else if (zero_r) begin
          res_nxt = f3_r[1] ? a_r : 32'hFFFFFFFF;
        end else if (f3_r[1]) begin
          res_nxt = neg_r ? 32'd0 - acc_nxt[63:32] : acc_nxt[63:32];
        end else begin
          res_nxt = neg_r ? 32'd0 - acc_nxt[31:0] : acc_nxt[31:0];
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign result = res_r;

  `ASSERT_CLK(a_done_after_busy, clk, rst_n, done_r |-> $past(busy_r), "done without run")
  `ASSERT_CLK(a_no_both, clk, rst_n, !(done_r && busy_r), "done while busy")
  `ASSERT_CLK(a_cnt_range, clk, rst_n, busy_r |-> cnt_r <= 6'd31, "count overrun")
endmodule

// ===== rtl/core/rv32im_instruction_executor.sv =====
// rv32im multicycle core with a private byte memory
// input channel (in_valid/in_stall): cmd 0 stores load_data little-endian at
//   load_addr, cmd 1 executes one instruction at the program counter
// result channel (out_valid/out_stall): one result transfer per input transfer
// config channel (cfg_valid/cfg_ready): index 0 start_pc, index 1 stack_top,
//   sampled on the first execute after reset
// steps: a word load writes four bytes (one byte write a cycle); a plain
//   instruction fetches four bytes, then does two register reads; loads
//   and stores add one memory access per byte; mul/div run in the shared
//   shift-add/subtract unit
// one item is in flight at a time: in_stall stays high until the result
//   transfer completes
// reset: a clearing pass writes zero to every memory byte, with in_stall
//   high; config writes are still taken
// out_valid holds with the payload stable while out_stall is high
`include "assert_macros.svh"
module rv32im_instruction_executor import rv32_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_load_addr,
  input  logic [31:0] in_load_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_pc_before,
  output logic [31:0] out_instr_word,
  output logic [31:0] out_next_pc,
  output logic [4:0]  out_dest_index,
  output logic [31:0] out_dest_value,
  output logic        out_dest_written,
  output logic [31:0] out_sys_arg0,
  output logic [31:0] out_sys_arg1,
  output logic [31:0] out_sys_arg2,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  localparam int AW = $clog2(MEM_BYTES);

  // byte memory, one access a cycle
  logic [7:0] mem [MEM_BYTES];
  logic [7:0] mem_q;
  logic       mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0] mem_wd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  // register file, one read or write a cycle
  logic [31:0] rf [32];
  logic [31:0] rf_q;
  logic        rf_we;
  logic [4:0]  rf_addr;
  logic [31:0] rf_wd;
  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_addr] <= rf_wd;
    rf_q <= rf[rf_addr];
  end

  state_t st_r, st_nxt;
  logic [AW:0]   clr_r, clr_nxt;
  logic [4:0]    rclr_r, rclr_nxt;
  logic          rclr_done_r, rclr_done_nxt;
  logic [15:0]   spc_r;
  logic [16:0]   stk_r;
  logic          started_r, started_nxt, halted_r, halted_nxt;
  logic [31:0]   pc_r, pc_nxt, ins_r, ins_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [31:0]   ea_r, ea_nxt, val_r, val_nxt, npc_r, npc_nxt;
  logic [2:0]    bcnt_r, bcnt_nxt, sub_r, sub_nxt;
  logic          vld_r, vld_nxt;
  logic [2:0]    ost_r, ost_nxt;
  logic [31:0]   opc_r, opc_nxt, oins_r, oins_nxt, onpc_r, onpc_nxt;
  logic [4:0]    ordi_r, ordi_nxt;
  logic [31:0]   orv_r, orv_nxt, s0_r, s0_nxt, s1_r, s1_nxt, s2_r, s2_nxt;
  logic          owr_r, owr_nxt;
  logic          cmd_r, cmd_nxt;
  logic [15:0]   la_r, la_nxt;
  logic [31:0]   ld_r, ld_nxt;

  md_req_t       md_req;
  logic          md_busy, md_done;
  logic [31:0]   md_res;

  rv32_muldiv u_md (.clk, .rst_n, .req(md_req), .busy(md_busy), .done(md_done),
                    .result(md_res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      rclr_r <= '0;
      rclr_done_r <= 1'b0;
      spc_r <= '0;
      stk_r <= 17'h10000;
      started_r <= 1'b0;
      halted_r <= 1'b0;
      pc_r <= '0;
      vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      rclr_r <= rclr_nxt;
      rclr_done_r <= rclr_done_nxt;
      started_r <= started_nxt;
      halted_r <= halted_nxt;
      pc_r <= pc_nxt;
      vld_r <= vld_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_START_PC:  spc_r <= cfg_wdata[15:0];
          CFG_STACK_TOP: stk_r <= cfg_wdata[16:0];
          default: ;
        endcase
      end
    end
    ins_r <= ins_nxt; a_r <= a_nxt; b_r <= b_nxt; ea_r <= ea_nxt;
    val_r <= val_nxt; npc_r <= npc_nxt; bcnt_r <= bcnt_nxt; sub_r <= sub_nxt;
    ost_r <= ost_nxt; opc_r <= opc_nxt; oins_r <= oins_nxt; onpc_r <= onpc_nxt;
    ordi_r <= ordi_nxt; orv_r <= orv_nxt; owr_r <= owr_nxt;
    s0_r <= s0_nxt; s1_r <= s1_nxt; s2_r <= s2_nxt;
    cmd_r <= cmd_nxt; la_r <= la_nxt; ld_r <= ld_nxt;
  end

  assign cfg_ready = 1'b1;
  assign in_stall = (st_r != S_IDLE) || vld_r;

  // decode fields
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi, imms, immb, immj;
  assign op = ins_r[6:0];
  assign rd = ins_r[11:7];
  assign f3 = ins_r[14:12];
  assign f7 = ins_r[31:25];
  assign immi = {{20{ins_r[31]}}, ins_r[31:20]};
  assign imms = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
  assign immb = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
  assign immj = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};

  // shared alu operands
  logic [31:0] opb, alu;
  logic        lt_s, lt_u, take;
  logic        wr;
  logic [2:0]  nbytes;
  logic        ldok;

  always_comb begin
    opb = (op == OP_REG || op == OP_BRANCH) ? b_r : immi;
    lt_s = $signed(a_r) < $signed(opb);
    lt_u = a_r < opb;
    alu = '0;
    case (f3)
      3'd0: alu = (op == OP_REG && f7[5]) ? a_r - opb : a_r + opb;
      3'd1: alu = a_r << opb[4:0];
      3'd2: alu = {31'd0, lt_s};
      3'd3: alu = {31'd0, lt_u};
      3'd4: alu = a_r ^ opb;
      3'd5: alu = ins_r[30] ? 32'($signed(a_r) >>> opb[4:0]) : a_r >> opb[4:0];
      3'd6: alu = a_r | opb;
      default: alu = a_r & opb;
    endcase
    take = 1'b0;
    case (f3)
      3'd0: take = a_r == b_r;
      3'd1: take = a_r != b_r;
      3'd4: take = lt_s;
      3'd5: take = !lt_s;
      3'd6: take = lt_u;
      3'd7: take = !lt_u;
      default: take = 1'b0;
    endcase
    nbytes = (f3[1:0] == 2'd0) ? 3'd1 : (f3[1:0] == 2'd1) ? 3'd2 : 3'd4;
    ldok = 32'(in_load_addr) + 32'd3 < 32'(MEM_BYTES);
  end

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; rclr_nxt = rclr_r; rclr_done_nxt = rclr_done_r;
    started_nxt = started_r; halted_nxt = halted_r; pc_nxt = pc_r;
    ins_nxt = ins_r; a_nxt = a_r; b_nxt = b_r; ea_nxt = ea_r; val_nxt = val_r;
    npc_nxt = npc_r; bcnt_nxt = bcnt_r; sub_nxt = sub_r;
    vld_nxt = vld_r; ost_nxt = ost_r; opc_nxt = opc_r; oins_nxt = oins_r;
    onpc_nxt = onpc_r; ordi_nxt = ordi_r; orv_nxt = orv_r; owr_nxt = owr_r;
    s0_nxt = s0_r; s1_nxt = s1_r; s2_nxt = s2_r;
    cmd_nxt = cmd_r; la_nxt = la_r; ld_nxt = ld_r;
    mem_we = 1'b0; mem_addr = '0; mem_wd = '0;
    rf_we = 1'b0; rf_addr = '0; rf_wd = '0;
    md_req = '{start: 1'b0, op: DOP_MUL, f3: f3, a: a_r, b: b_r};
    wr = 1'b0;
    if (vld_r && !out_stall) vld_nxt = 1'b0;
    unique case (st_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_r[AW-1:0];
        rf_we = !rclr_done_r;
        rf_addr = rclr_r;
        rclr_nxt = rclr_r + 5'd1;
        if (rclr_r == 5'd31) rclr_done_nxt = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(MEM_BYTES - 1) && (rclr_done_r || rclr_r == 5'd31))
          st_nxt = S_IDLE;
        else if (clr_r == (AW+1)'(MEM_BYTES - 1)) clr_nxt = clr_r;
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          la_nxt = in_load_addr;
          ld_nxt = in_load_data;
          bcnt_nxt = '0;
          ost_nxt = ST_EXEC; opc_nxt = '0; oins_nxt = '0; onpc_nxt = '0;
          ordi_nxt = '0; orv_nxt = '0; owr_nxt = 1'b0;
          s0_nxt = '0; s1_nxt = '0; s2_nxt = '0;
          if (!in_cmd) begin
            if (ldok) st_nxt = S_LDW;
            else begin
              ost_nxt = ST_LOADOR;
              vld_nxt = 1'b1;
            end
          end else if (halted_r) begin
            ost_nxt = ST_HALT; opc_nxt = pc_r; onpc_nxt = pc_r; vld_nxt = 1'b1;
          end else if (!started_r) begin
            // seed pc and sp on the first execute
            started_nxt = 1'b1;
            pc_nxt = {16'd0, spc_r};
            rf_we = 1'b1; rf_addr = 5'd2; rf_wd = {15'd0, stk_r};
            st_nxt = S_FETCH;
          end else st_nxt = S_FETCH;
        end
      end
      S_LDW: begin
        mem_we = 1'b1;
        mem_addr = AW'(32'(la_r) + 32'(bcnt_r));
        mem_wd = ld_r[8*bcnt_r[1:0] +: 8];
        bcnt_nxt = bcnt_r + 3'd1;
        if (bcnt_r == 3'd3) begin
          ost_nxt = ST_LOADED; vld_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      S_FETCH: begin
        // issue reads in bcnt 0..3, collect each byte in the cycle after its read
        mem_addr = AW'(pc_r + 32'(bcnt_r[1:0]));
        if (bcnt_r != 3'd0) ins_nxt[8*(bcnt_r[1:0]-2'd1) +: 8] = mem_q;
        bcnt_nxt = bcnt_r + 3'd1;
        if (bcnt_r == 3'd4) begin
          ins_nxt[31:24] = mem_q;
          st_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        opc_nxt = pc_r; oins_nxt = ins_r; npc_nxt = pc_r + 32'd4;
        if (ins_r == '0) begin
          halted_nxt = 1'b1; ost_nxt = ST_HALT; onpc_nxt = pc_r; vld_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          rf_addr = ins_r[19:15];
          sub_nxt = '0;
          st_nxt = S_RDA;
        end
      end
      S_RDA: begin
        // sub counts register reads: rs1, rs2, a7, a0, a1, a2
        unique case (sub_r)
          3'd0: rf_addr = ins_r[24:20];
          3'd1: rf_addr = 5'd17;
          3'd2: rf_addr = 5'd10;
          3'd3: rf_addr = 5'd11;
          default: rf_addr = 5'd12;
        endcase
        unique case (sub_r)
          3'd0: a_nxt = rf_q;
          3'd1: b_nxt = rf_q;
          3'd2: val_nxt = rf_q;
          3'd3: s0_nxt = rf_q;
          3'd4: s1_nxt = rf_q;
          default: s2_nxt = rf_q;
        endcase
        sub_nxt = sub_r + 3'd1;
        if (sub_r == 3'd5 || (sub_r == 3'd1 && op != OP_SYSTEM)) st_nxt = S_EXEC;
      end
      S_EXEC: begin
        st_nxt = S_DONE;
        bcnt_nxt = '0;
        unique case (op)
          OP_LOAD: begin
            ea_nxt = a_r + immi; val_nxt = '0;
            if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) st_nxt = S_DONE;
            else st_nxt = S_MEMRD;
          end
          OP_STORE: begin
            ea_nxt = a_r + imms;
            if (f3 < 3'd3) st_nxt = S_MEMWR;
          end
          OP_IMM: begin
            val_nxt = alu;
            ordi_nxt = rd; orv_nxt = alu; owr_nxt = 1'b1;
          end
          OP_LUI: begin
            ordi_nxt = rd; orv_nxt = {ins_r[31:12], 12'd0}; owr_nxt = 1'b1;
          end
          OP_AUIPC: begin
            ordi_nxt = rd; orv_nxt = {ins_r[31:12], 12'd0} + pc_r; owr_nxt = 1'b1;
          end
          OP_REG: begin
            if (f7 == 7'd0 || (f7 == 7'd32 && (f3 == 3'd0 || f3 == 3'd5))) begin
              ordi_nxt = rd; orv_nxt = alu; owr_nxt = 1'b1;
            end else if (f7 == 7'd1) begin
              md_req.start = 1'b1;
              md_req.op = f3[2] ? DOP_DIV : DOP_MUL;
              st_nxt = S_MD;
            end
          end
          OP_JAL: begin
            ordi_nxt = rd; orv_nxt = pc_r + 32'd4; owr_nxt = 1'b1;
            npc_nxt = pc_r + immj;
          end
          OP_JALR: begin
            ordi_nxt = rd; orv_nxt = pc_r + 32'd4; owr_nxt = 1'b1;
            npc_nxt = (a_r + immi) & 32'hFFFFFFFE;
          end
          OP_BRANCH: if (take) npc_nxt = pc_r + immb;
          OP_SYSTEM: begin
            if (val_r == SYS_READ) ost_nxt = ST_READ;
            else if (val_r == SYS_WRITE) ost_nxt = ST_WRITE;
            else if (val_r == SYS_EXIT) begin
              ost_nxt = ST_EXIT; halted_nxt = 1'b1;
            end else begin
              ost_nxt = ST_UNK; halted_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_MD: begin
        if (md_done) begin
          ordi_nxt = rd; orv_nxt = md_res; owr_nxt = 1'b1; st_nxt = S_DONE;
        end
      end
      S_MEMRD: begin
        mem_addr = AW'(ea_r + 32'(bcnt_r[1:0]));
        if (bcnt_r != 3'd0) val_nxt[8*(bcnt_r[1:0]-2'd1) +: 8] = mem_q;
        bcnt_nxt = bcnt_r + 3'd1;
        if (bcnt_r == {1'b0, nbytes[1:0]} + {nbytes[2], 2'b00}) begin
          ordi_nxt = rd; owr_nxt = 1'b1; st_nxt = S_DONE;
          unique case (f3)
            3'd0: orv_nxt = {{24{val_nxt[7]}}, val_nxt[7:0]};
            3'd1: orv_nxt = {{16{val_nxt[15]}}, val_nxt[15:0]};
            3'd4: orv_nxt = {24'd0, val_nxt[7:0]};
            3'd5: orv_nxt = {16'd0, val_nxt[15:0]};
            default: orv_nxt = val_nxt;
          endcase
        end
      end
      S_MEMWR: begin
        mem_we = 1'b1;
        mem_addr = AW'(ea_r + 32'(bcnt_r[1:0]));
        mem_wd = b_r[8*bcnt_r[1:0] +: 8];
        bcnt_nxt = bcnt_r + 3'd1;
        if (bcnt_r + 3'd1 == nbytes) st_nxt = S_DONE;
      end
      S_DONE: begin
        // commit destination and present the result
        if (owr_r && ordi_r != 5'd0) begin
          rf_we = 1'b1; rf_addr = ordi_r; rf_wd = orv_r;
        end else begin
          ordi_nxt = '0; orv_nxt = '0; owr_nxt = 1'b0;
        end
        if (op == OP_SYSTEM) begin
          s0_nxt = s0_r; s1_nxt = s1_r; s2_nxt = s2_r;
        end
        pc_nxt = npc_r; onpc_nxt = npc_r;
        vld_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    wr = owr_r;
  end

  // outputs come straight from the result registers; wr is folded into out_dest_written
  assign out_valid = vld_r;
  assign out_status = ost_r;
  assign out_pc_before = opc_r;
  assign out_instr_word = oins_r;
  assign out_next_pc = onpc_r;
  assign out_dest_index = ordi_r;
  assign out_dest_value = orv_r;
  assign out_dest_written = owr_r && wr;
  assign out_sys_arg0 = s0_r;
  assign out_sys_arg1 = s1_r;
  assign out_sys_arg2 = s2_r;

  `ASSERT_CLK(a_one_in_flight, clk, rst_n, vld_r |-> in_stall, "accept with result pending")
  `ASSERT_CLK(a_hold, clk, rst_n, (vld_r && out_stall) |=> vld_r, "result dropped")
  `ASSERT_CLK(a_md_only_in_md, clk, rst_n, md_busy |-> st_r == S_MD, "divider runs stray")
endmodule

// ===== tb/rv32im_instruction_executor_tb.sv =====
`timescale 1ns / 1ps

module rv32im_instruction_executor_tb;
  import rv32_pkg::*;

  // funct7 groups of register-register operations
  localparam logic [6:0] F7_BASE   = 7'd0;
  localparam logic [6:0] F7_ALT    = 7'd32;
  localparam logic [6:0] F7_MULDIV = 7'd1;

  // one result: status, pc_before, instr_word, next_pc, dest_index,
  // dest_value, dest_written, sys_arg0..2, each widened to 32 bits
  typedef logic [9:0][31:0] outcome_t;

  class exec_scoreboard;
    logic [7:0]  mem [65536];
    logic [31:0] rf [32];
    logic [31:0] pc;
    bit          started, halted;
    logic [15:0] start_pc;
    logic [16:0] stack_top;
    outcome_t    pending[$];
    int          errors, n_in, n_out;
    int          status_seen[8];
    string       field_name[10] = '{"status", "pc_before", "instr_word", "next_pc",
                                    "dest_index", "dest_value", "dest_written",
                                    "sys_arg0", "sys_arg1", "sys_arg2"};

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      foreach (rf[i]) rf[i] = 32'h0;
      pc = 32'h0;
      start_pc = 16'h0;
      stack_top = 17'd65536;
    endfunction

    function logic [31:0] next_fetch();
      return started ? pc : {16'h0, start_pc};
    endfunction

    function logic [31:0] rd_mem(logic [31:0] a, int n);
      logic [31:0] v, x, t;
      v = 32'h0;
      for (int i = 0; i < n; i++) begin
        x = a + i;
        t = {24'h0, mem[x[15:0]]};
        v |= t << (8 * i);
      end
      return v;
    endfunction

    function void wr_mem(logic [31:0] a, int n, logic [31:0] v);
      logic [31:0] x;
      for (int i = 0; i < n; i++) begin
        x = a + i;
        mem[x[15:0]] = v[8*i +: 8];
      end
    endfunction

    function logic [31:0] shift_ra(logic [31:0] x, logic [4:0] s);
      return $signed(x) >>> s;
    endfunction

    function bit alu_reg(input logic [6:0] f7, input logic [2:0] f3,
                         input logic [31:0] a, input logic [31:0] b,
                         output logic [31:0] r);
      logic [63:0] p;
      logic [31:0] ma, mb, m;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      r = 32'h0;
      if (f7 == F7_BASE) begin
        case (f3)
          3'd0: r = a + b;
          3'd1: r = a << b[4:0];
          3'd2: r = {31'h0, $signed(a) < $signed(b)};
          3'd3: r = {31'h0, a < b};
          3'd4: r = a ^ b;
          3'd5: r = a >> b[4:0];
          3'd6: r = a | b;
          default: r = a & b;
        endcase
        return 1;
      end
      if (f7 == F7_ALT) begin
        if (f3 == 3'd0) begin r = a - b; return 1; end
        if (f3 == 3'd5) begin r = shift_ra(a, b[4:0]); return 1; end
        return 0;
      end
      if (f7 != F7_MULDIV) return 0;
      case (f3)
        3'd0: r = a * b;
        3'd1: begin p = {{32{a[31]}}, a} * {{32{b[31]}}, b}; r = p[63:32]; end
        3'd2: begin p = {{32{a[31]}}, a} * {32'h0, b}; r = p[63:32]; end
        3'd3: begin p = {32'h0, a} * {32'h0, b}; r = p[63:32]; end
        3'd4: begin
          m = (b == 0) ? 32'h0 : ma / mb;
          r = (b == 0) ? 32'hFFFFFFFF : ((a[31] != b[31]) ? -m : m);
        end
        3'd5: r = (b == 0) ? 32'hFFFFFFFF : a / b;
        3'd6: begin
          m = (b == 0) ? 32'h0 : ma % mb;
          r = (b == 0) ? a : (a[31] ? -m : m);
        end
        default: r = (b == 0) ? a : a % b;
      endcase
      return 1;
    endfunction

    function void write_reg(bit idx, logic [31:0] v);
      if (idx == CFG_START_PC) start_pc = v[15:0];
      else stack_top = v[16:0];
    endfunction

    // works out the result of one accepted input transfer
    function void note_input(bit cmd, logic [15:0] addr, logic [31:0] data);
      outcome_t r;
      logic [31:0] ins, a, b, immi, npc, val, ea, imm, v;
      logic [6:0] op;
      logic [4:0] rd;
      logic [2:0] f3;
      bit wr, take;
      r = '0;
      n_in++;
      if (!cmd) begin
        if ({1'b0, addr} + 17'd3 >= 17'd65536) r[0] = ST_LOADOR;
        else begin
          wr_mem({16'h0, addr}, 4, data);
          r[0] = ST_LOADED;
        end
        pending.push_back(r);
        return;
      end
      if (halted) begin
        r[0] = ST_HALT; r[1] = pc; r[3] = pc;
        pending.push_back(r);
        return;
      end
      if (!started) begin
        pc = {16'h0, start_pc};
        rf[2] = {15'h0, stack_top};
        started = 1;
      end
      ins = rd_mem(pc, 4);
      r[1] = pc;
      r[2] = ins;
      if (ins == 0) begin
        halted = 1;
        r[0] = ST_HALT; r[3] = pc;
        pending.push_back(r);
        return;
      end
      op = ins[6:0]; rd = ins[11:7]; f3 = ins[14:12];
      a = rf[ins[19:15]]; b = rf[ins[24:20]];
      immi = {{20{ins[31]}}, ins[31:20]};
      npc = pc + 4;
      val = 32'h0;
      wr = 0;
      r[0] = ST_EXEC;
      case (op)
        OP_LOAD: begin
          ea = a + immi;
          wr = 1;
          case (f3)
            3'd0: begin v = rd_mem(ea, 1); val = {{24{v[7]}}, v[7:0]}; end
            3'd1: begin v = rd_mem(ea, 2); val = {{16{v[15]}}, v[15:0]}; end
            3'd2: val = rd_mem(ea, 4);
            3'd4: val = rd_mem(ea, 1);
            3'd5: val = rd_mem(ea, 2);
            default: wr = 0;
          endcase
        end
        OP_STORE: begin
          ea = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
          if (f3 == 3'd0) wr_mem(ea, 1, b);
          else if (f3 == 3'd1) wr_mem(ea, 2, b);
          else if (f3 == 3'd2) wr_mem(ea, 4, b);
        end
        OP_IMM: begin
          wr = 1;
          case (f3)
            3'd0: val = a + immi;
            3'd1: val = a << ins[24:20];
            3'd2: val = {31'h0, $signed(a) < $signed(immi)};
            3'd3: val = {31'h0, a < immi};
            3'd4: val = a ^ immi;
            3'd5: val = ins[30] ? shift_ra(a, ins[24:20]) : a >> ins[24:20];
            3'd6: val = a | immi;
            default: val = a & immi;
          endcase
        end
        OP_LUI: begin wr = 1; val = {ins[31:12], 12'h0}; end
        OP_AUIPC: begin wr = 1; val = {ins[31:12], 12'h0} + pc; end
        OP_REG: wr = alu_reg(ins[31:25], f3, a, b, val);
        OP_JAL: begin
          imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
          wr = 1; val = pc + 4; npc = pc + imm;
        end
        OP_JALR: begin
          wr = 1; val = pc + 4; npc = (a + immi) & 32'hFFFFFFFE;
        end
        OP_BRANCH: begin
          imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
          case (f3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = $signed(a) >= $signed(b);
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: take = 0;
          endcase
          if (take) npc = pc + imm;
        end
        OP_SYSTEM: begin
          r[7] = rf[10]; r[8] = rf[11]; r[9] = rf[12];
          if (rf[17] == SYS_READ) r[0] = ST_READ;
          else if (rf[17] == SYS_WRITE) r[0] = ST_WRITE;
          else if (rf[17] == SYS_EXIT) begin r[0] = ST_EXIT; halted = 1; end
          else begin r[0] = ST_UNK; halted = 1; end
        end
        default: ;
      endcase
      if (wr && rd != 0) begin
        rf[rd] = val;
        r[4] = {27'h0, rd}; r[5] = val; r[6] = 32'd1;
      end
      pc = npc;
      r[3] = npc;
      pending.push_back(r);
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch at result %0d, %s: got %h expected %h", n_out, what, got, want);
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      n_out++;
      status_seen[got[0][2:0]]++;
      if (pending.size() == 0) begin
        flag_mismatch("unexpected result", got[0], 32'h0);
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 10; i++)
        if (got[i] !== want[i]) flag_mismatch(field_name[i], got[i], want[i]);
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_cmd;
  logic [15:0] in_load_addr;
  logic [31:0] in_load_data;
  logic        out_valid, out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_pc_before, out_instr_word, out_next_pc, out_dest_value;
  logic [4:0]  out_dest_index;
  logic        out_dest_written;
  logic [31:0] out_sys_arg0, out_sys_arg1, out_sys_arg2;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_wdata;

  exec_scoreboard sb = new();
  int  hold_cnt;
  bit  held;
  wire calm = sb.n_in >= 600 && sb.n_in < 800;  // stretch with no idling on either side

  rv32im_instruction_executor dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block locks up
  initial begin
    #10ms;
    $display("rv32im_instruction_executor_tb NOT OK");
    $finish;
  end

  // one input transfer; the predictor sees it at the accepting edge
  task automatic send_item(bit cmd, logic [15:0] addr, logic [31:0] data);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_load_addr <= addr;
    in_load_data <= data;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, addr, data);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // config write; upper wdata bits are junk the block must ignore
  task automatic write_cfg(bit idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  // wait for every expected result, then let the block settle
  task automatic drain();
    drop_valid();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // put an instruction word at the next fetch address, split across the
  // top of memory and address 0 when it wraps
  task automatic place(logic [31:0] ins);
    logic [31:0] f;
    int k;
    f = sb.next_fetch();
    if (f[15:0] <= 16'd65532) send_item(1'b0, f[15:0], ins);
    else begin
      k = 65536 - f[15:0];
      send_item(1'b0, 16'd65532, ins << (8 * (4 - k)));
      send_item(1'b0, 16'd0, ins >> (8 * k));
    end
  endtask

  task automatic run_instr(logic [31:0] ins);
    place(ins);
    send_item(1'b1, $urandom, $urandom);
  endtask

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  // random instruction that never halts the core
  function automatic logic [31:0] gen_instr();
    logic [31:0] w, t;
    logic [4:0] rd;
    logic [6:0] op;
    int k;
    w = $urandom;
    k = $urandom_range(99);
    rd = $urandom_range(1, 31);
    t = $urandom_range(4095);
    if (k < 12) begin
      // load corner values into registers: min int, -1, small
      case ($urandom_range(2))
        0: w = {20'h80000, rd, OP_LUI};
        1: w = enc_i(12'hFFF, 5'd0, 3'd0, rd, OP_IMM);
        default: w = enc_i(t[11:0], 5'd0, 3'd0, rd, OP_IMM);
      endcase
      return w;
    end
    if (k < 30) begin
      case ($urandom_range(3))
        0: w[31:25] = F7_BASE;
        1: w[31:25] = F7_ALT;
        2: w[31:25] = F7_MULDIV;
        default: ;
      endcase
      op = OP_REG;
    end
    else if (k < 45) op = OP_IMM;
    else if (k < 52) op = OP_LUI;
    else if (k < 57) op = OP_AUIPC;
    else if (k < 65) op = OP_LOAD;
    else if (k < 73) op = OP_STORE;
    else if (k < 83) op = OP_BRANCH;
    else if (k < 87) op = OP_JAL;
    else if (k < 90) op = OP_JALR;
    else if (k < 95) begin
      // ecall only once a7 asks for read or write, otherwise set a7 up
      if (sb.rf[17] == SYS_READ || sb.rf[17] == SYS_WRITE) op = OP_SYSTEM;
      else begin
        t = SYS_READ + $urandom_range(1);
        return enc_i(t[11:0], 5'd0, 3'd0, 5'd17, OP_IMM);
      end
    end
    else begin
      op = w[6:0];
      if (op == OP_SYSTEM) op = 7'h7F;
    end
    w[6:0] = op;
    if (w == 0) w = 32'h80;
    return w;
  endfunction

  // result side: random stalls plus one long hold-off
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_result({out_sys_arg2, out_sys_arg1, out_sys_arg0, {31'h0, out_dest_written},
                         out_dest_value, {27'h0, out_dest_index}, out_next_pc,
                         out_instr_word, out_pc_before, {29'h0, out_status}});
      out_stall <= hold_cnt > 0 || (!calm && $urandom_range(99) < 29);
    end
  end

  // long hold-off counter, started once after some results
  initial begin
    hold_cnt = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) hold_cnt--;
      else if (!held && sb.n_out >= 200) begin
        hold_cnt = 400;
        held = 1;
      end
    end
  end

  initial begin
    logic [31:0] t;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= 1'b0;
    in_load_addr <= '0;
    in_load_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // config extremes first, then the setting the run actually uses;
    // only the last values matter, they are sampled on the first execute
    write_cfg(CFG_START_PC, {16'hFFFF, 16'd65532});
    write_cfg(CFG_STACK_TOP, {15'h7FFF, 17'd0});
    write_cfg(CFG_START_PC, 32'h0);
    write_cfg(CFG_STACK_TOP, 32'd65536);
    t = $urandom;
    write_cfg(CFG_START_PC, {t[31:16], t[15:2], 2'b00});
    t = $urandom_range(65536);
    write_cfg(CFG_STACK_TOP, t | ($urandom << 17));

    // word loads at the edges of memory, two of them out of range
    send_item(1'b0, 16'd0, 32'h0);
    send_item(1'b0, 16'd65532, 32'hFFFFFFFF);
    send_item(1'b0, 16'd65533, $urandom);
    send_item(1'b0, 16'd65535, 32'h0);

    // directed: signed overflow, divide by zero, mulh, srai, x0 guard,
    // jalr reading rs1 before writing it, write syscall
    run_instr({20'h80000, 5'd5, OP_LUI});
    run_instr(enc_i(12'hFFF, 5'd0, 3'd0, 5'd6, OP_IMM));
    run_instr(enc_r(F7_MULDIV, 5'd6, 5'd5, 3'd4, 5'd7));
    run_instr(enc_r(F7_MULDIV, 5'd6, 5'd5, 3'd6, 5'd8));
    run_instr(enc_r(F7_MULDIV, 5'd0, 5'd5, 3'd5, 5'd9));
    run_instr(enc_r(F7_MULDIV, 5'd0, 5'd5, 3'd7, 5'd10));
    run_instr(enc_r(F7_MULDIV, 5'd6, 5'd5, 3'd1, 5'd11));
    run_instr(enc_i(12'h41F, 5'd5, 3'd5, 5'd12, OP_IMM));
    run_instr(enc_r(F7_ALT, 5'd6, 5'd5, 3'd0, 5'd0));
    run_instr(enc_i(12'h0, 5'd1, 3'd0, 5'd1, OP_JALR));
    run_instr(enc_i(SYS_WRITE[11:0], 5'd0, 3'd0, 5'd17, OP_IMM));
    run_instr({25'h0, OP_SYSTEM});

    // random program, each instruction placed at the next fetch address
    // just before it runs, with some stray word loads mixed in
    while (sb.n_in < 1250) begin
      if ($urandom_range(99) < 10) send_item(1'b0, $urandom, $urandom);
      else run_instr(gen_instr());
      if (sb.n_in >= 700 && sb.n_in < 703) begin
        // late config writes while idle must have no effect
        drain();
        write_cfg(CFG_START_PC, $urandom);
        write_cfg(CFG_STACK_TOP, $urandom);
      end
    end

    // finish with one of the halting cases, then poke the halted core
    case ($urandom_range(2))
      0: run_instr(32'h0);
      1: begin
        run_instr(enc_i(SYS_EXIT[11:0], 5'd0, 3'd0, 5'd17, OP_IMM));
        run_instr({25'h0, OP_SYSTEM});
      end
      default: begin
        run_instr(enc_i(12'd93, 5'd0, 3'd0, 5'd17, OP_IMM));
        run_instr({25'h0, OP_SYSTEM});
      end
    endcase
    send_item(1'b1, $urandom, $urandom);
    send_item(1'b0, $urandom_range(65532), $urandom);
    send_item(1'b1, $urandom, $urandom);
    drain();

    $display("covered %0d transfers in, %0d out: executed %0d, loaded %0d, out of range %0d",
             sb.n_in, sb.n_out, sb.status_seen[ST_EXEC], sb.status_seen[ST_LOADED],
             sb.status_seen[ST_LOADOR]);
    $display("halt %0d, exit %0d, unknown syscall %0d, read %0d, write %0d; %0d mismatches",
             sb.status_seen[ST_HALT], sb.status_seen[ST_EXIT], sb.status_seen[ST_UNK],
             sb.status_seen[ST_READ], sb.status_seen[ST_WRITE], sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("rv32im_instruction_executor_tb OK");
    else
      $display("rv32im_instruction_executor_tb NOT OK");
    $finish;
  end

endmodule
